[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FTRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define FTRB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[rtl/ftrb_pkg.sv]
package ftrb_pkg;

    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    // Distances and lengths inside the ring reach RING_DEPTH itself.
    localparam int DIST_W     = PTR_W + 1;

    localparam int CNT_W    = 48;
    localparam int ID_W     = 22;
    localparam int ST_W     = 16;
    localparam int NAME_W   = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PID  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_DUMP   = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_REC   = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BUSY  = 2'd2
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF = 2'd0,
        MODE_ALL = 2'd1,
        MODE_ONE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   tid;
        logic [ST_W-1:0]   state;
        logic [NAME_W-1:0] name_low;
        logic [NAME_W-1:0] name_high;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic    latch;
        logic    rec_write;
        logic    do_clear;
        logic    set_pend;
        logic    clr_pend;
        logic    win_pend;
        logic    win_dump;
        logic    calc_win;
        logic    calc_slot;
        logic    rd_issue;
        logic    emit_st;
        t_status st_code;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic pass;
        logic pend_valid;
        logic pend_hit;
        logic dump_later;
        logic empty;
        logic last_read;
    } t_dp_sts;

endpackage

[rtl/ftrb_ram.sv]
module ftrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ftrb_ctrl.sv]
module ftrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ftrb_pkg::t_dp_sts i_sts,
    output ftrb_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);

    import ftrb_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_CHK  = 6'b000100,
        S_WIN  = 6'b001000,
        S_BND  = 6'b010000,
        S_RD   = 6'b100000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state       = r_state;
        n_cmd         = '0;
        n_cmd.st_code = ST_REC;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_sts.op)
                    OP_RECORD: begin
                        if (i_sts.pass) begin
                            n_cmd.rec_write = 1'b1;
                            n_state         = S_CHK;
                        end
                    end
                    OP_CLEAR: begin
                        n_cmd.do_clear = 1'b1;
                        // A held dump goes out now with the mark it took at request time.
                        if (i_sts.pend_valid) begin
                            n_cmd.clr_pend = 1'b1;
                            n_cmd.win_pend = 1'b1;
                            n_state        = S_WIN;
                        end
                    end
                    OP_DUMP: begin
                        if (i_sts.pend_valid) begin
                            n_cmd.emit_st = 1'b1;
                            n_cmd.st_code = ST_BUSY;
                        end else if (i_sts.dump_later) begin
                            n_cmd.set_pend = 1'b1;
                        end else begin
                            n_cmd.win_dump = 1'b1;
                            n_state        = S_WIN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CHK: begin
                n_state = S_IDLE;
                if (i_sts.pend_valid && i_sts.pend_hit) begin
                    n_cmd.clr_pend = 1'b1;
                    n_cmd.win_pend = 1'b1;
                    n_state        = S_WIN;
                end
            end
            S_WIN: begin
                n_cmd.calc_win = 1'b1;
                n_state        = S_BND;
            end
            S_BND: begin
                if (i_sts.empty) begin
                    n_cmd.emit_st = 1'b1;
                    n_cmd.st_code = ST_EMPTY;
                    n_state       = S_IDLE;
                end else begin
                    n_cmd.calc_slot = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RD: begin
                n_cmd.rd_issue = 1'b1;
                if (i_sts.last_read) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = n_cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/ftrb_dp.sv]
module ftrb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ftrb_pkg::t_dp_cmd                 i_cmd,
    output ftrb_pkg::t_dp_sts                 o_sts,
    input  logic                              i_cfg_we,
    input  logic [ftrb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ftrb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [ftrb_pkg::OP_W-1:0]         i_operation,
    input  logic [ftrb_pkg::ID_W-1:0]         i_event_pid,
    input  logic [ftrb_pkg::ID_W-1:0]         i_event_tid,
    input  logic [ftrb_pkg::ST_W-1:0]         i_event_state,
    input  logic [ftrb_pkg::NAME_W-1:0]       i_name_low,
    input  logic [ftrb_pkg::NAME_W-1:0]       i_name_high,
    input  logic [ftrb_pkg::CNT_W-1:0]        i_dump_from,
    output logic                              o_valid,
    output logic [ftrb_pkg::STATUS_W-1:0]     o_status,
    output logic [ftrb_pkg::ID_W-1:0]         o_rec_pid,
    output logic [ftrb_pkg::ID_W-1:0]         o_rec_tid,
    output logic [ftrb_pkg::ST_W-1:0]         o_rec_state,
    output logic [ftrb_pkg::NAME_W-1:0]       o_rec_name_low,
    output logic [ftrb_pkg::NAME_W-1:0]       o_rec_name_high,
    output logic [ftrb_pkg::CNT_W-1:0]        o_end_count,
    output logic                              o_last
);

    import ftrb_pkg::*;

    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(RING_DEPTH);
    localparam logic [DIST_W-1:0] DEPTH_D = DIST_W'(RING_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(RING_DEPTH - 1);

    // Configuration.
    logic [MODE_W-1:0] r_mode;
    logic [ID_W-1:0]   r_tpid;

    // Latched item.
    t_op              r_op;
    t_rec             r_rec;
    logic [CNT_W-1:0] r_from;

    // Ring state.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_mark;
    logic [PTR_W-1:0] r_wp;
    logic             r_pend_valid;
    logic [CNT_W-1:0] r_pend_target;
    logic [CNT_W-1:0] r_pend_mark;

    // Window being read out.
    logic [CNT_W-1:0]  r_wmark;
    logic [CNT_W-1:0]  r_wtarget;
    logic [CNT_W-1:0]  r_begin;
    logic [CNT_W-1:0]  r_end;
    logic [PTR_W-1:0]  r_slot;
    logic [DIST_W-1:0] r_rem;

    // Result registers.
    logic    r_rd_vld;
    logic    r_rd_last;
    logic    r_st_vld;
    t_status r_st_code;

    logic [CNT_W-1:0]  n_count;
    logic [PTR_W-1:0]  n_wp;
    logic [CNT_W-1:0]  n_target;
    logic [CNT_W-1:0]  n_low;
    logic [CNT_W-1:0]  n_begin;
    logic [CNT_W-1:0]  n_end;
    logic [DIST_W-1:0] n_dist;
    logic [DIST_W-1:0] n_len;
    logic [DIST_W-1:0] n_wp_ext;
    logic [PTR_W-1:0]  n_slot;
    logic [PTR_W-1:0]  n_slot_inc;
    logic              n_pass;
    logic [REC_W-1:0]  n_rdata;
    t_rec              n_rd_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
            r_tpid <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_wdata[MODE_W-1:0];
                CFG_PID:  r_tpid <= i_cfg_wdata[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op            <= t_op'(i_operation);
            r_rec.pid       <= i_event_pid;
            r_rec.tid       <= i_event_tid;
            r_rec.state     <= i_event_state;
            r_rec.name_low  <= i_name_low;
            r_rec.name_high <= i_name_high;
            r_from          <= i_dump_from;
        end
    end

    // Mode three traces nothing, like mode zero.
    assign n_pass = (r_mode == MODE_ALL) || ((r_mode == MODE_ONE) && (r_rec.pid == r_tpid));

    assign n_count = r_count + 1'b1;
    // The write pointer follows the count modulo the depth, also across a count wrap.
    assign n_wp    = ((n_count == '0) || (r_wp == LAST_SLOT)) ? '0 : r_wp + 1'b1;

    assign n_target = (r_from == '0) ? r_count : r_from + DEPTH_C;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_wp          <= '0;
            r_mark        <= '0;
            r_pend_valid  <= 1'b0;
            r_pend_target <= '0;
            r_pend_mark   <= '0;
        end else begin
            if (i_cmd.rec_write) begin
                r_count <= n_count;
                r_wp    <= n_wp;
            end
            if (i_cmd.do_clear) begin
                r_mark <= r_count;
            end
            if (i_cmd.set_pend) begin
                r_pend_valid  <= 1'b1;
                r_pend_target <= n_target;
                r_pend_mark   <= r_mark;
            end else if (i_cmd.clr_pend) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign n_low   = r_count - DEPTH_C;
    assign n_begin = ((r_count >= DEPTH_C) && (n_low > r_wmark)) ? n_low : r_wmark;
    assign n_end   = (r_count < r_wtarget) ? r_count : r_wtarget;

    // A non-empty window lies within one depth below the count, so the start slot
    // is the write pointer stepped back by that distance.
    assign n_dist   = DIST_W'(r_count - r_begin);
    assign n_len    = DIST_W'(r_end - r_begin);
    assign n_wp_ext = DIST_W'(r_wp);
    assign n_slot   = (n_wp_ext >= n_dist) ? PTR_W'(n_wp_ext - n_dist)
                                           : PTR_W'(n_wp_ext + DEPTH_D - n_dist);
    assign n_slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_pend) begin
            r_wmark   <= r_pend_mark;
            r_wtarget <= r_pend_target;
        end else if (i_cmd.win_dump) begin
            r_wmark   <= r_mark;
            r_wtarget <= n_target;
        end
        if (i_cmd.calc_win) begin
            r_begin <= n_begin;
            r_end   <= n_end;
        end
        if (i_cmd.calc_slot) begin
            r_slot <= n_slot;
            r_rem  <= n_len;
        end else if (i_cmd.rd_issue) begin
            r_slot <= n_slot_inc;
            r_rem  <= r_rem - 1'b1;
        end
    end

    ftrb_ram #(
        .WIDTH(REC_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.rec_write),
        .i_waddr(r_wp),
        .i_wdata(r_rec),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(r_slot),
        .o_rdata(n_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_st_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
            r_st_vld <= i_cmd.emit_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= (r_rem == DIST_W'(1));
        r_st_code <= i_cmd.st_code;
    end

    assign n_rd_rec = n_rdata;

    assign o_valid         = r_rd_vld | r_st_vld;
    assign o_status        = r_rd_vld ? ST_REC : r_st_code;
    assign o_rec_pid       = r_rd_vld ? n_rd_rec.pid       : '0;
    assign o_rec_tid       = r_rd_vld ? n_rd_rec.tid       : '0;
    assign o_rec_state     = r_rd_vld ? n_rd_rec.state     : '0;
    assign o_rec_name_low  = r_rd_vld ? n_rd_rec.name_low  : '0;
    assign o_rec_name_high = r_rd_vld ? n_rd_rec.name_high : '0;
    assign o_end_count     = r_count;
    assign o_last          = r_rd_vld ? r_rd_last : 1'b1;

    assign o_sts.op         = r_op;
    assign o_sts.pass       = n_pass;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.pend_hit   = (r_count >= r_pend_target);
    assign o_sts.dump_later = (n_target > r_count);
    assign o_sts.empty      = (r_end <= r_begin);
    assign o_sts.last_read  = (r_rem == DIST_W'(1));

endmodule

[rtl/filtered_trace_ring_buffer.sv]
// Channel   | Signals                                     | Transfer
// ----------+---------------------------------------------+-------------------------------
// item in   | start, busy, i_operation .. i_dump_from     | edge with start high, busy low
// config    | i_cfg_we, i_cfg_idx, i_cfg_wdata            | edge with i_cfg_we high
// result    | o_valid, o_status .. o_last                 | every cycle o_valid is high
//
// A passing record holds busy through execute and pending check; other items through execute.
// A window adds busy states for bounds, start slot, then one ring read a cycle through the
// single read port. An empty window stops at the bounds check with one status result.
// Results leave in the cycle after their read or status decision; the receiver cannot stall.
// Synchronous active-low reset clears the counts, marks, pending dump and filter;
// the ring contents stay undefined until written and need no clearing pass.
module filtered_trace_ring_buffer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [ftrb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ftrb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [ftrb_pkg::OP_W-1:0]         i_operation,
    input  logic [ftrb_pkg::ID_W-1:0]         i_event_pid,
    input  logic [ftrb_pkg::ID_W-1:0]         i_event_tid,
    input  logic [ftrb_pkg::ST_W-1:0]         i_event_state,
    input  logic [ftrb_pkg::NAME_W-1:0]       i_name_low,
    input  logic [ftrb_pkg::NAME_W-1:0]       i_name_high,
    input  logic [ftrb_pkg::CNT_W-1:0]        i_dump_from,
    output logic                              o_valid,
    output logic [ftrb_pkg::STATUS_W-1:0]     o_status,
    output logic [ftrb_pkg::ID_W-1:0]         o_rec_pid,
    output logic [ftrb_pkg::ID_W-1:0]         o_rec_tid,
    output logic [ftrb_pkg::ST_W-1:0]         o_rec_state,
    output logic [ftrb_pkg::NAME_W-1:0]       o_rec_name_low,
    output logic [ftrb_pkg::NAME_W-1:0]       o_rec_name_high,
    output logic [ftrb_pkg::CNT_W-1:0]        o_end_count,
    output logic                              o_last
);

    import ftrb_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_busy;

    ftrb_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd),
        .o_busy (w_busy)
    );

    ftrb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operation    (i_operation),
        .i_event_pid    (i_event_pid),
        .i_event_tid    (i_event_tid),
        .i_event_state  (i_event_state),
        .i_name_low     (i_name_low),
        .i_name_high    (i_name_high),
        .i_dump_from    (i_dump_from),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_rec_pid      (o_rec_pid),
        .o_rec_tid      (o_rec_tid),
        .o_rec_state    (o_rec_state),
        .o_rec_name_low (o_rec_name_low),
        .o_rec_name_high(o_rec_name_high),
        .o_end_count    (o_end_count),
        .o_last         (o_last)
    );

    assign busy = w_busy;

    `include "assert_macros.svh"

    `FTRB_ASSERT(a_start_busy, start && !busy |=> busy, "transfer did not raise busy")
    `FTRB_ASSERT(a_read_busy, w_cmd.rd_issue |-> busy, "ring read issued while idle")
    `FTRB_ASSERT(a_read_result, w_cmd.rd_issue |=> o_valid && o_status == ST_REC, "read lost")
    `FTRB_NEVER(a_last_no_read, o_valid && o_last && w_cmd.rd_issue, "read after final result")

endmodule

[sim/ftrb_trace_checker.sv]
`timescale 1ns / 100ps

module ftrb_trace_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [ftrb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ftrb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [ftrb_pkg::OP_W-1:0]         i_operation,
    input  logic [ftrb_pkg::ID_W-1:0]         i_event_pid,
    input  logic [ftrb_pkg::ID_W-1:0]         i_event_tid,
    input  logic [ftrb_pkg::ST_W-1:0]         i_event_state,
    input  logic [ftrb_pkg::NAME_W-1:0]       i_name_low,
    input  logic [ftrb_pkg::NAME_W-1:0]       i_name_high,
    input  logic [ftrb_pkg::CNT_W-1:0]        i_dump_from,
    input  logic                              o_valid,
    input  logic [ftrb_pkg::STATUS_W-1:0]     o_status,
    input  logic [ftrb_pkg::ID_W-1:0]         o_rec_pid,
    input  logic [ftrb_pkg::ID_W-1:0]         o_rec_tid,
    input  logic [ftrb_pkg::ST_W-1:0]         o_rec_state,
    input  logic [ftrb_pkg::NAME_W-1:0]       o_rec_name_low,
    input  logic [ftrb_pkg::NAME_W-1:0]       o_rec_name_high,
    input  logic [ftrb_pkg::CNT_W-1:0]        o_end_count,
    input  logic                              o_last,
    output int                                mismatch_count,
    output int                                results_owed,
    output int                                results_checked
);
    import ftrb_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   tid;
        logic [ST_W-1:0]   state;
        logic [NAME_W-1:0] name_low;
        logic [NAME_W-1:0] name_high;
        logic [CNT_W-1:0]  end_count;
        logic              last;
    } t_trace_beat;

    t_trace_beat owed_q[$];

    // Shadow copy of the capture ring and its bookkeeping.
    t_rec              ring_copy [RING_DEPTH];
    logic [CNT_W-1:0]  evt_count;
    logic [CNT_W-1:0]  clr_mark;
    logic              hold_valid;
    logic [CNT_W-1:0]  hold_target;
    logic [CNT_W-1:0]  hold_mark;
    logic [MODE_W-1:0] flt_mode;
    logic [ID_W-1:0]   flt_pid;

    function automatic void push_status(input t_status st);
        t_trace_beat beat;
        beat = '0;
        beat.status = st;
        beat.end_count = evt_count;
        beat.last = 1'b1;
        owed_q.push_back(beat);
    endfunction

    // Records with counts in [max(count - depth, mark), min(count, target)).
    function automatic void push_window(input logic [CNT_W-1:0] mark,
                                        input logic [CNT_W-1:0] target);
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] idx;
        t_trace_beat      beat;
        t_rec             entry;
        lo = mark;
        hi = (evt_count < target) ? evt_count : target;
        if (evt_count >= DEPTH_CNT && evt_count - DEPTH_CNT > lo) begin
            lo = evt_count - DEPTH_CNT;
        end
        if (hi <= lo) begin
            push_status(ST_EMPTY);
            return;
        end
        for (idx = lo; idx < hi; idx++) begin
            entry = ring_copy[idx[PTR_W-1:0]];
            beat.status = ST_REC;
            beat.pid = entry.pid;
            beat.tid = entry.tid;
            beat.state = entry.state;
            beat.name_low = entry.name_low;
            beat.name_high = entry.name_high;
            beat.end_count = evt_count;
            beat.last = (idx + 1'b1 == hi);
            owed_q.push_back(beat);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_trace_beat      want;
        logic [CNT_W-1:0] target;
        logic             passes;
        if (!i_rst_n) begin
            owed_q.delete();
            evt_count = '0;
            clr_mark = '0;
            hold_valid = 1'b0;
            hold_target = '0;
            hold_mark = '0;
            flt_mode = MODE_OFF;
            flt_pid = '0;
            mismatch_count = 0;
            results_checked = 0;
        end else begin
            // A result can only come from an earlier transfer, so check it first.
            if (o_valid) begin
                if (owed_q.size() == 0) begin
                    $error("result with status %0d arrived with none expected", o_status);
                    mismatch_count++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("status", 64'(want.status), 64'(o_status));
                    check_field("rec_pid", 64'(want.pid), 64'(o_rec_pid));
                    check_field("rec_tid", 64'(want.tid), 64'(o_rec_tid));
                    check_field("rec_state", 64'(want.state), 64'(o_rec_state));
                    check_field("rec_name_low", want.name_low, o_rec_name_low);
                    check_field("rec_name_high", want.name_high, o_rec_name_high);
                    check_field("end_count", 64'(want.end_count), 64'(o_end_count));
                    check_field("last", 64'(want.last), 64'(o_last));
                    results_checked++;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: flt_mode = i_cfg_wdata[MODE_W-1:0];
                    CFG_PID:  flt_pid = i_cfg_wdata[ID_W-1:0];
                    default: ;
                endcase
            end

            if (start && !busy) begin
                case (i_operation)
                    OP_RECORD: begin
                        passes = (flt_mode == MODE_ALL) ||
                                 (flt_mode == MODE_ONE && i_event_pid == flt_pid);
                        if (passes) begin
                            ring_copy[evt_count[PTR_W-1:0]].pid = i_event_pid;
                            ring_copy[evt_count[PTR_W-1:0]].tid = i_event_tid;
                            ring_copy[evt_count[PTR_W-1:0]].state = i_event_state;
                            ring_copy[evt_count[PTR_W-1:0]].name_low = i_name_low;
                            ring_copy[evt_count[PTR_W-1:0]].name_high = i_name_high;
                            evt_count = evt_count + 1'b1;
                            if (hold_valid && evt_count >= hold_target) begin
                                hold_valid = 1'b0;
                                push_window(hold_mark, hold_target);
                            end
                        end
                    end
                    OP_CLEAR: begin
                        clr_mark = evt_count;
                        // A held dump is released with the mark it was requested with.
                        if (hold_valid) begin
                            hold_valid = 1'b0;
                            push_window(hold_mark, hold_target);
                        end
                    end
                    OP_DUMP: begin
                        if (hold_valid) begin
                            push_status(ST_BUSY);
                        end else begin
                            target = (i_dump_from == '0) ? evt_count
                                                         : i_dump_from + DEPTH_CNT;
                            if (target > evt_count) begin
                                hold_valid = 1'b1;
                                hold_target = target;
                                hold_mark = clr_mark;
                            end else begin
                                push_window(clr_mark, target);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        results_owed = owed_q.size();
    end

endmodule

[sim/filtered_trace_ring_buffer_tb.sv]
`timescale 1ns / 100ps

module filtered_trace_ring_buffer_tb;
    import ftrb_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int PHASES = 7;
    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(RING_DEPTH);

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   tid;
        logic [ST_W-1:0]   state;
        logic [NAME_W-1:0] name_low;
        logic [NAME_W-1:0] name_high;
        logic [CNT_W-1:0]  from;
    } t_trace_cmd;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic [OP_W-1:0]       i_operation;
    logic [ID_W-1:0]       i_event_pid;
    logic [ID_W-1:0]       i_event_tid;
    logic [ST_W-1:0]       i_event_state;
    logic [NAME_W-1:0]     i_name_low;
    logic [NAME_W-1:0]     i_name_high;
    logic [CNT_W-1:0]      i_dump_from;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [ID_W-1:0]       o_rec_pid;
    logic [ID_W-1:0]       o_rec_tid;
    logic [ST_W-1:0]       o_rec_state;
    logic [NAME_W-1:0]     o_rec_name_low;
    logic [NAME_W-1:0]     o_rec_name_high;
    logic [CNT_W-1:0]      o_end_count;
    logic                  o_last;

    int mismatches;
    int owed;
    int checked;

    // Stimulus-side view of the filter, used to aim dump targets and to pick record pids.
    logic [MODE_W-1:0] cur_mode;
    logic [ID_W-1:0]   cur_pid;
    logic [CNT_W-1:0]  rec_total;
    int n_record, n_clear, n_dump, n_other, n_cfg;

    filtered_trace_ring_buffer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_operation),
        .i_event_pid     (i_event_pid),
        .i_event_tid     (i_event_tid),
        .i_event_state   (i_event_state),
        .i_name_low      (i_name_low),
        .i_name_high     (i_name_high),
        .i_dump_from     (i_dump_from),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_rec_pid       (o_rec_pid),
        .o_rec_tid       (o_rec_tid),
        .o_rec_state     (o_rec_state),
        .o_rec_name_low  (o_rec_name_low),
        .o_rec_name_high (o_rec_name_high),
        .o_end_count     (o_end_count),
        .o_last          (o_last)
    );

    ftrb_trace_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_operation),
        .i_event_pid     (i_event_pid),
        .i_event_tid     (i_event_tid),
        .i_event_state   (i_event_state),
        .i_name_low      (i_name_low),
        .i_name_high     (i_name_high),
        .i_dump_from     (i_dump_from),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_rec_pid       (o_rec_pid),
        .o_rec_tid       (o_rec_tid),
        .o_rec_state     (o_rec_state),
        .o_rec_name_low  (o_rec_name_low),
        .o_rec_name_high (o_rec_name_high),
        .o_end_count     (o_end_count),
        .o_last          (o_last),
        .mismatch_count  (mismatches),
        .results_owed    (owed),
        .results_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_trace_cmd make_cmd(input logic [OP_W-1:0] op);
        t_trace_cmd c;
        logic [63:0] r;
        c.op = op;
        r = rand64();
        c.pid = r[ID_W-1:0];
        c.tid = r[63:64-ID_W];
        r = rand64();
        c.state = r[ST_W-1:0];
        c.from = r[63:64-CNT_W];
        c.name_low = rand64();
        c.name_high = rand64();
        return c;
    endfunction

    function automatic logic [ID_W-1:0] rand_pid();
        logic [63:0] r;
        int pick;
        r = rand64();
        pick = $urandom_range(0, 99);
        if (cur_mode == MODE_ONE && pick < 75) return cur_pid;
        if (pick < 83) return '0;
        if (pick < 91) return '1;
        return r[ID_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] pick_from();
        logic [63:0] r;
        int pick;
        r = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 35) return '0;
        // Target a few records ahead so the dump is held and then released.
        if (pick < 65) return rec_total + $urandom_range(1, 12) - DEPTH_CNT;
        // Target at or behind the count unless the subtraction wraps: a partial or empty window right away.
        if (pick < 80) return rec_total - $urandom_range(0, 100) - DEPTH_CNT;
        // Far target: held until a clear releases it.
        if (pick < 92) return r[CNT_W-1:0];
        return (pick < 96) ? '1 : 48'd1;
    endfunction

    task automatic send_item(input t_trace_cmd c);
        start <= 1'b1;
        i_operation <= c.op;
        i_event_pid <= c.pid;
        i_event_tid <= c.tid;
        i_event_state <= c.state;
        i_name_low <= c.name_low;
        i_name_high <= c.name_high;
        i_dump_from <= c.from;
        do @(posedge i_clk); while (busy);
        case (c.op)
            OP_RECORD: begin
                n_record++;
                if (cur_mode == MODE_ALL || (cur_mode == MODE_ONE && c.pid == cur_pid)) begin
                    rec_total++;
                end
            end
            OP_CLEAR: n_clear++;
            OP_DUMP:  n_dump++;
            default:  n_other++;
        endcase
    endtask

    task automatic idle_gap();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 55) len = 0;
        else if (pick < 90) len = $urandom_range(1, 3);
        else len = $urandom_range(8, 40);
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Waits until every expected result has come and the block is idle again.
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (busy || owed != 0);
        // An item without results may still be finishing its check cycles.
        repeat (8) @(negedge i_clk);
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_MODE) cur_mode = data[MODE_W-1:0];
        else cur_pid = data[ID_W-1:0];
        n_cfg++;
    endtask

    initial begin : watchdog
        repeat (RUN_LIMIT) @(posedge i_clk);
        $error("run did not finish within %0d cycles", RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [MODE_W-1:0] phase_mode [PHASES];
        int                phase_len [PHASES];
        logic [ID_W-1:0]   phase_pid;
        logic [63:0]       r;
        t_trace_cmd        c;
        logic              burst;
        int                pick;

        phase_mode = '{MODE_ALL, MODE_ONE, MODE_UNUSED, MODE_ALL, MODE_ONE, MODE_OFF,
                       MODE_ALL};
        phase_len = '{75, 75, 15, 75, 75, 15, 70};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        i_operation = OP_RECORD;
        i_event_pid = '0;
        i_event_tid = '0;
        i_event_state = '0;
        i_name_low = '0;
        i_name_high = '0;
        i_dump_from = '0;
        cur_mode = MODE_OFF;
        cur_pid = '0;
        rec_total = '0;
        n_record = 0;
        n_clear = 0;
        n_dump = 0;
        n_other = 0;
        n_cfg = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Nothing is traced yet: an empty dump, a dropped record,
        // an unused operation code.
        c = make_cmd(OP_DUMP);
        c.from = '0;
        send_item(c);
        send_item(make_cmd(OP_RECORD));
        send_item(make_cmd(OP_UNUSED));
        settle();
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_ALL));
        cfg_write(CFG_PID, '1);

        c = make_cmd(OP_RECORD);
        c.pid = '1;
        c.tid = '1;
        c.state = '1;
        c.name_low = '1;
        c.name_high = '1;
        send_item(c);
        c.pid = '0;
        c.tid = '0;
        c.state = '0;
        c.name_low = '0;
        c.name_high = '0;
        send_item(c);
        c.pid = 22'h2AAAAA;
        c.tid = 22'h155555;
        c.state = 16'h5A5A;
        c.name_low = 64'hAAAA_AAAA_AAAA_AAAA;
        c.name_high = 64'h5555_5555_5555_5555;
        send_item(c);
        c = make_cmd(OP_DUMP);
        c.from = '0;
        send_item(c);
        // Held dump, a second dump that finds it busy, then a clear releasing it.
        c.from = 48'd1;
        send_item(c);
        c.from = '0;
        send_item(c);
        send_item(make_cmd(OP_CLEAR));
        send_item(c);
        idle_gap();
        send_item(make_cmd(OP_RECORD));
        c.from = '1;
        send_item(c);
        send_item(make_cmd(OP_CLEAR));
        // A target two records ahead, reached by the second record.
        c.from = rec_total + 2'd2 - DEPTH_CNT;
        send_item(c);
        send_item(make_cmd(OP_RECORD));
        idle_gap();
        send_item(make_cmd(OP_RECORD));
        settle();

        r = rand64();
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_ONE));
        cfg_write(CFG_PID, r[ID_W-1:0]);
        c = make_cmd(OP_RECORD);
        c.pid = cur_pid;
        send_item(c);
        c = make_cmd(OP_RECORD);
        c.pid = cur_pid ^ 22'd1;
        send_item(c);
        c = make_cmd(OP_DUMP);
        c.from = 48'hFFFF_FFFF_FFC0;
        send_item(c);
        settle();
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_UNUSED));
        send_item(make_cmd(OP_RECORD));
        c.from = '0;
        send_item(c);

        // Random part, one filter setting per phase.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            r = rand64();
            if (p == 1) phase_pid = '1;
            else if (p == 4) phase_pid = '0;
            else phase_pid = r[ID_W-1:0];
            cfg_write(CFG_PID, phase_pid);
            cfg_write(CFG_MODE, CFG_DATA_W'(phase_mode[p]));
            burst = 1'b0;
            for (int i = 0; i < phase_len[p]; i++) begin
                if (i % 20 == 0) burst = ($urandom_range(0, 9) < 3);
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    c = make_cmd(OP_RECORD);
                    c.pid = rand_pid();
                end else if (pick < 76) begin
                    c = make_cmd(OP_CLEAR);
                end else if (pick < 97) begin
                    c = make_cmd(OP_DUMP);
                    c.from = pick_from();
                end else begin
                    c = make_cmd(OP_UNUSED);
                end
                send_item(c);
                if (!burst) idle_gap();
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (owed != 0) begin
            $error("%0d expected results never arrived", owed);
        end
        $display("Sent %0d records, %0d clears, %0d dumps, %0d unused codes; %0d config writes.",
                 n_record, n_clear, n_dump, n_other, n_cfg);
        $display("Checked %0d results against the prediction.", checked);
        if (mismatches == 0 && owed == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ftrb_pkg.sv
rtl/ftrb_ram.sv
rtl/ftrb_ctrl.sv
rtl/ftrb_dp.sv
rtl/filtered_trace_ring_buffer.sv
sim/ftrb_trace_checker.sv
sim/filtered_trace_ring_buffer_tb.sv
